/* design/dctms_pkg.sv */
package dctms_pkg;

  localparam int unsigned KEY_WINDOW_DEF  = 3;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  localparam int unsigned BATCH_LEN   = 18;
  localparam int unsigned BATCH_SHIFT = 4;
  localparam int unsigned BCNT_W      = 5;

  localparam int unsigned LIGHT_LEN   = 6;
  localparam int unsigned LIGHT_SHIFT = 2;
  localparam int unsigned LFILL_W     = 3;

  localparam int unsigned OUT_W  = 12;
  localparam int unsigned SLOT_W = 2;

  typedef enum logic [1:0] {
    CH_KEY   = 2'b01,
    CH_LIGHT = 2'b10
  } chan_e;

endpackage

/* design/dctms_in_if.sv */
interface dctms_in_if #(
  parameter int unsigned SAMPLE_BITS = dctms_pkg::SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] conv_value;
  logic                   conv_fail;
  logic                   tick_20ms;

  modport source (output valid, conv_value, conv_fail, tick_20ms, input ready);
  modport sink   (input valid, conv_value, conv_fail, tick_20ms, output ready);
endinterface

/* design/dctms_out_if.sv */
interface dctms_out_if ();
  logic                         valid;
  logic                         ready;
  logic [dctms_pkg::OUT_W-1:0]  key_level;
  logic [dctms_pkg::OUT_W-1:0]  light_level;
  logic                         key_updated;
  logic                         light_updated;
  logic                         channel_select;

  modport source (output valid, key_level, light_level, key_updated, light_updated,
                  channel_select, input ready);
  modport sink   (input valid, key_level, light_level, key_updated, light_updated,
                  channel_select, output ready);
endinterface

/* design/dctms_batch.sv */
module dctms_batch #(
  parameter int unsigned SAMPLE_BITS = dctms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [SAMPLE_BITS-1:0] value_i,
  input  logic                   fail_i,
  output logic                   done_o,
  output logic [SAMPLE_BITS-1:0] value_o
);
  import dctms_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_BITS + 5;

  logic [BCNT_W-1:0]      cnt_q, cnt_d, cnt_inc;
  logic [SUM_W-1:0]       sum_q, sum_d, sum_inc, trimmed;
  logic [SAMPLE_BITS-1:0] min_q, min_d, min_n;
  logic [SAMPLE_BITS-1:0] max_q, max_d, max_n;
  logic                   full;

  always_comb begin
    cnt_inc = cnt_q + 1'b1;
    sum_inc = sum_q + SUM_W'(value_i);
    min_n   = (value_i < min_q) ? value_i : min_q;
    max_n   = (value_i > max_q) ? value_i : max_q;
    full    = (cnt_inc >= BCNT_W'(BATCH_LEN));
    trimmed = sum_inc - SUM_W'(min_n) - SUM_W'(max_n);

    done_o  = fail_i || full;
    value_o = fail_i ? '0 : SAMPLE_BITS'(trimmed >> BATCH_SHIFT);

    cnt_d = cnt_q;
    sum_d = sum_q;
    min_d = min_q;
    max_d = max_q;
    if (en_i) begin
      if (done_o) begin
        // close the batch, a failed conversion included
        cnt_d = '0;
        sum_d = '0;
        min_d = '1;
        max_d = '0;
      end else begin
        cnt_d = cnt_inc;
        sum_d = sum_inc;
        min_d = min_n;
        max_d = max_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      min_q <= '1;
      max_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
      min_q <= min_d;
      max_q <= max_d;
    end
  end

endmodule

/* design/dual_channel_trimmed_mean_sampler.sv */
// Channel  Dir  Handshake      Beat contents
// in_i     in   valid/ready    conv_value, conv_fail, tick_20ms
// out_o    out  valid/ready    key_level, light_level, key_updated, light_updated,
//                              channel_select
// cfg      in   cfg_we_i       key_pick_slot (cfg_wdata_i)
//
// One beat in, one beat out; a beat is taken every cycle while out_o keeps up.
// The batch and channel state update in the accepting cycle
// and the result register shows the new levels on the next edge.
// out_o stalls hold the result register and deassert in_i.ready only while a
// result is pending and not taken. Reset clears all state except the key window,
// whose slots are written before they are read; no clearing pass.
module dual_channel_trimmed_mean_sampler #(
  parameter int unsigned KEY_WINDOW  = dctms_pkg::KEY_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = dctms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dctms_pkg::SLOT_W-1:0]  cfg_wdata_i,
  dctms_in_if.sink                      in_i,
  dctms_out_if.source                   out_o
);
  import dctms_pkg::*;

  localparam int unsigned FILL_W = (KEY_WINDOW > 1) ? $clog2(KEY_WINDOW) : 1;
  localparam int unsigned LSUM_W = SAMPLE_BITS + 3;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(KEY_WINDOW - 1);

  logic                   fire;
  logic                   bdone;
  logic [SAMPLE_BITS-1:0] bval;

  logic [SLOT_W-1:0]      pick_q;
  chan_e                  chan_q, chan_d;
  logic                   ovalid_q, ovalid_d;
  logic                   kupd_q, kupd_d, lupd_q, lupd_d;

  // key channel
  logic [1:0]             skip_q, skip_d, skip_inc;
  logic [FILL_W-1:0]      kfill_q, kfill_d, kidx, slot;
  logic [OUT_W-1:0]       window_q [KEY_WINDOW];
  logic [OUT_W-1:0]       key_out_q, key_out_d, pick_val;
  logic                   key_go, key_take, key_last;

  // light channel
  logic [LFILL_W-1:0]     lfill_q, lfill_d, lfill_inc;
  logic [LSUM_W-1:0]      lsum_q, lsum_d, lsum_n;
  logic [SAMPLE_BITS-1:0] lmin_q, lmin_d, lmin_n;
  logic [SAMPLE_BITS-1:0] lmax_q, lmax_d, lmax_n;
  logic [OUT_W-1:0]       light_out_q, light_out_d, light_val;
  logic                   light_go;

  assign in_i.ready = !ovalid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;

  dctms_batch #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_batch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire),
    .value_i (in_i.conv_value),
    .fail_i  (in_i.conv_fail),
    .done_o  (bdone),
    .value_o (bval)
  );

  always_comb begin
    key_go   = bdone && (chan_q == CH_KEY);
    light_go = bdone && (chan_q == CH_LIGHT);

    // skip every other value unless the tick is set; a tick keeps a pending skip
    skip_inc = skip_q + 2'd1;
    skip_d   = skip_q;
    key_take = 1'b1;
    if (!in_i.tick_20ms) begin
      if (skip_inc < 2'd2) begin
        skip_d   = skip_inc;
        key_take = 1'b0;
      end else begin
        skip_d = '0;
      end
    end
    if (!key_go) skip_d = skip_q;

    kidx     = (kfill_q > FILL_LAST) ? '0 : kfill_q;
    key_last = (kidx == FILL_LAST);
    slot     = (32'(pick_q) >= KEY_WINDOW) ? FILL_LAST : FILL_W'(pick_q);
    // the slot being written this beat is not in the window yet: bypass it
    pick_val = (slot == kidx) ? OUT_W'(bval) : window_q[slot];

    kfill_d   = kfill_q;
    key_out_d = key_out_q;
    kupd_d    = 1'b0;
    if (key_go && key_take) begin
      kfill_d = key_last ? '0 : kidx + 1'b1;
      if (key_last) begin
        key_out_d = pick_val;
        kupd_d    = 1'b1;
      end
    end

    lfill_inc = lfill_q + 1'b1;
    lsum_n    = lsum_q + LSUM_W'(bval);
    lmin_n    = (bval < lmin_q) ? bval : lmin_q;
    lmax_n    = (bval > lmax_q) ? bval : lmax_q;
    light_val = OUT_W'((lsum_n - LSUM_W'(lmax_n) - LSUM_W'(lmin_n)) >> LIGHT_SHIFT);

    lfill_d     = lfill_q;
    lsum_d      = lsum_q;
    lmin_d      = lmin_q;
    lmax_d      = lmax_q;
    light_out_d = light_out_q;
    lupd_d      = 1'b0;
    if (light_go) begin
      lfill_d = lfill_inc;
      // drop the first value after switching
      if (lfill_inc >= LFILL_W'(2)) begin
        if (lfill_inc >= LFILL_W'(LIGHT_LEN + 1)) begin
          light_out_d = light_val;
          lupd_d      = 1'b1;
          lfill_d     = '0;
          lsum_d      = '0;
          lmin_d      = '1;
          lmax_d      = '0;
        end else begin
          lsum_d = lsum_n;
          lmin_d = lmin_n;
          lmax_d = lmax_n;
        end
      end
    end

    chan_d = chan_q;
    if (kupd_d) chan_d = CH_LIGHT;
    if (lupd_d) chan_d = CH_KEY;

    ovalid_d = ovalid_q;
    if (fire) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_q      <= '0;
      chan_q      <= CH_KEY;
      ovalid_q    <= 1'b0;
      kupd_q      <= 1'b0;
      lupd_q      <= 1'b0;
      skip_q      <= '0;
      kfill_q     <= '0;
      key_out_q   <= '0;
      lfill_q     <= '0;
      lsum_q      <= '0;
      lmin_q      <= '1;
      lmax_q      <= '0;
      light_out_q <= '0;
    end else begin
      if (cfg_we_i) pick_q <= cfg_wdata_i;
      ovalid_q <= ovalid_d;
      if (fire) begin
        chan_q      <= chan_d;
        kupd_q      <= kupd_d;
        lupd_q      <= lupd_d;
        skip_q      <= skip_d;
        kfill_q     <= kfill_d;
        key_out_q   <= key_out_d;
        lfill_q     <= lfill_d;
        lsum_q      <= lsum_d;
        lmin_q      <= lmin_d;
        lmax_q      <= lmax_d;
        light_out_q <= light_out_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && key_go && key_take) window_q[kidx] <= OUT_W'(bval);
  end

  // state only advances when no result is pending or the pending one is taken, so it is the result
  assign out_o.valid          = ovalid_q;
  assign out_o.key_level      = key_out_q;
  assign out_o.light_level    = light_out_q;
  assign out_o.key_updated    = kupd_q;
  assign out_o.light_updated  = lupd_q;
  assign out_o.channel_select = (chan_q == CH_LIGHT);

  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.key_updated && out_o.light_updated))
    else $error("key and light published in the same beat");

  a_key_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.key_updated) |-> out_o.channel_select)
    else $error("key publish did not switch to light");

  a_light_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.light_updated) |-> !out_o.channel_select)
    else $error("light publish did not switch to key");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_o.valid)
    else $error("accepted beat produced no result");

endmodule

/* dv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dctms_pkg::*;

  localparam int unsigned SW          = SAMPLE_BITS_DEF;
  localparam int unsigned KW          = KEY_WINDOW_DEF;
  localparam int unsigned HOLD_CYCLES = 80;

  typedef struct packed {
    logic [SW-1:0] value;
    logic          fail;
    logic          tick;
  } conv_beat_t;

  typedef struct packed {
    logic [OUT_W-1:0] key_level;
    logic [OUT_W-1:0] light_level;
    logic             key_updated;
    logic             light_updated;
    logic             channel_select;
  } levels_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [SLOT_W-1:0] cfg_wdata_i;

  dctms_in_if  in_if ();
  dctms_out_if out_if ();

  dual_channel_trimmed_mean_sampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  conv_beat_t conv_q[$];
  levels_t    levels_q[$];
  int         mismatches = 0;

  // Sampler state as the block should hold it.
  bit [BCNT_W-1:0]  batch_cnt;
  bit [16:0]        batch_sum;
  bit [SW-1:0]      batch_lo;
  bit [SW-1:0]      batch_hi;
  chan_e            active_chan;
  bit [1:0]         skip_cnt;
  bit [1:0]         key_fill;
  bit [SW-1:0]      key_win [KW];
  bit [LFILL_W-1:0] light_fill;
  bit [14:0]        light_sum;
  bit [SW-1:0]      light_lo;
  bit [SW-1:0]      light_hi;
  bit [OUT_W-1:0]   key_out;
  bit [OUT_W-1:0]   light_out;
  bit [SLOT_W-1:0]  pick_slot;

  function automatic levels_t sampler_step(logic [SW-1:0] value, logic fail, logic tick);
    bit [16:0]   trimmed;
    bit [14:0]   light_trim;
    bit [SW-1:0] batch_val;
    bit          done;
    bit          take;
    int unsigned slot;
    levels_t     r;
    done = 1'b0;
    batch_val = '0;
    r = '0;
    if (fail) begin
      done = 1'b1;
    end else begin
      batch_sum = batch_sum + value;
      if (value > batch_hi) batch_hi = value;
      if (value < batch_lo) batch_lo = value;
      batch_cnt = batch_cnt + 1'b1;
      if (batch_cnt >= BATCH_LEN) begin
        trimmed = batch_sum - batch_lo - batch_hi;
        batch_val = SW'(trimmed >> BATCH_SHIFT);
        done = 1'b1;
      end
    end
    if (done) begin
      batch_cnt = '0;
      batch_sum = '0;
      batch_lo = '1;
      batch_hi = '0;
      if (active_chan == CH_KEY) begin
        take = 1'b1;
        // a set tick takes the value but leaves a pending skip in place
        if (!tick) begin
          skip_cnt = skip_cnt + 1'b1;
          if (skip_cnt < 2) take = 1'b0;
          else skip_cnt = '0;
        end
        if (take) begin
          if (key_fill >= KW) key_fill = '0;
          key_win[key_fill] = batch_val;
          key_fill = key_fill + 1'b1;
          if (key_fill >= KW) begin
            key_fill = '0;
            slot = (pick_slot >= KW) ? KW - 1 : pick_slot;
            key_out = key_win[slot];
            active_chan = CH_LIGHT;
            r.key_updated = 1'b1;
          end
        end
      end else begin
        // drop the first value after the switch, then collect the window
        light_fill = light_fill + 1'b1;
        if (light_fill >= 2) begin
          light_sum = light_sum + batch_val;
          if (batch_val > light_hi) light_hi = batch_val;
          if (batch_val < light_lo) light_lo = batch_val;
          if (light_fill >= LIGHT_LEN + 1) begin
            light_trim = light_sum - light_hi - light_lo;
            light_out = OUT_W'(light_trim >> LIGHT_SHIFT);
            light_fill = '0;
            light_sum = '0;
            light_hi = '0;
            light_lo = '1;
            active_chan = CH_KEY;
            r.light_updated = 1'b1;
          end
        end
      end
    end
    r.key_level = key_out;
    r.light_level = light_out;
    r.channel_select = (active_chan == CH_LIGHT);
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sender: bursts of beats from conv_q with random gaps between them.
  int         burst_left = 1;
  int         gap_left = 0;
  conv_beat_t next_beat;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.conv_value <= '0;
      in_if.conv_fail <= 1'b0;
      in_if.tick_20ms <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        levels_q.push_back(sampler_step(in_if.conv_value, in_if.conv_fail, in_if.tick_20ms));
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (conv_q.size() > 0) begin
          next_beat = conv_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.conv_value <= next_beat.value;
          in_if.conv_fail <= next_beat.fail;
          in_if.tick_20ms <= next_beat.tick;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
            gap_left = $urandom_range(1, 6);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall mode changes at random intervals; one long hold-off on request.
  bit hold_req = 1'b0;
  bit hold_done;
  int hold_left;
  int rx_span;
  int rx_mode;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_done = 1'b0;
      hold_left = 0;
      rx_span = 0;
      rx_mode = 0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (rx_span == 0) begin
          rx_span = $urandom_range(20, 100);
          rx_mode = $urandom_range(0, 2);
        end else begin
          rx_span--;
        end
        case (rx_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 1) == 1);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  levels_t got_levels;

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready) begin
      if (levels_q.size() == 0) begin
        $error("result beat with no expected levels pending");
        mismatches++;
      end else begin
        got_levels = levels_q.pop_front();
        check_field("key_level", 16'(got_levels.key_level), 16'(out_if.key_level));
        check_field("light_level", 16'(got_levels.light_level), 16'(out_if.light_level));
        check_field("key_updated", 16'(got_levels.key_updated), 16'(out_if.key_updated));
        check_field("light_updated", 16'(got_levels.light_updated),
                    16'(out_if.light_updated));
        check_field("channel_select", 16'(got_levels.channel_select),
                    16'(out_if.channel_select));
      end
    end
  end

  task automatic push_conv(logic [SW-1:0] value, logic fail, logic tick);
    conv_beat_t b;
    b.value = value;
    b.fail = fail;
    b.tick = tick;
    conv_q.push_back(b);
  endtask

  task automatic drain();
    while (conv_q.size() != 0 || in_if.valid || levels_q.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_slot(bit [SLOT_W-1:0] slot);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= slot;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pick_slot = slot;
  endtask

  // About half whole batches, the rest cut short by a failed conversion.
  task automatic queue_batches(int n_beats);
    int          queued;
    int          len;
    int          style;
    logic [SW-1:0] base;
    logic [SW-1:0] v;
    queued = 0;
    while (queued < n_beats) begin
      style = $urandom_range(0, 2);
      base = SW'($urandom_range(0, (1 << SW) - 1));
      len = ($urandom_range(0, 1) == 0) ? int'(BATCH_LEN)
                                        : int'($urandom_range(0, BATCH_LEN - 1));
      for (int i = 0; i < len; i++) begin
        case (style)
          0: v = SW'($urandom_range(0, (1 << SW) - 1));
          1: v = ($urandom_range(0, 1) == 0) ? '0 : '1;
          default: v = (base > (1 << SW) - 17) ? SW'(base - $urandom_range(0, 15))
                                                : SW'(base + $urandom_range(0, 15));
        endcase
        push_conv(v, 1'b0, $urandom_range(0, 2) == 0);
      end
      if (len < BATCH_LEN) begin
        push_conv(SW'($urandom_range(0, (1 << SW) - 1)), 1'b1, $urandom_range(0, 2) == 0);
        queued++;
      end
      queued += len;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.conv_value = '0;
    in_if.conv_fail = 1'b0;
    in_if.tick_20ms = 1'b0;
    out_if.ready = 1'b0;

    batch_cnt = '0;
    batch_sum = '0;
    batch_lo = '1;
    batch_hi = '0;
    active_chan = CH_KEY;
    skip_cnt = '0;
    key_fill = '0;
    light_fill = '0;
    light_sum = '0;
    light_lo = '1;
    light_hi = '0;
    key_out = '0;
    light_out = '0;
    pick_slot = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_slot(2'd0);
    // skip the first key value, then fill the window from a full extreme batch and two failed conversions
    push_conv('1, 1'b1, 1'b0);
    for (int i = 0; i < BATCH_LEN; i++)
      push_conv((i % 2 == 0) ? '0 : '1, 1'b0, i == BATCH_LEN - 1);
    push_conv('0, 1'b1, 1'b0);
    push_conv('1, 1'b1, 1'b1);
    repeat (3) push_conv('0, 1'b1, 1'b1);

    set_slot(2'd3);
    hold_req = 1'b1;
    queue_batches(145);
    set_slot(2'd1);
    queue_batches(145);
    set_slot(2'd2);
    queue_batches(145);
    set_slot(2'd0);
    queue_batches(145);

    drain();
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* dual_channel_trimmed_mean_sampler.f */
design/dctms_pkg.sv
design/dctms_in_if.sv
design/dctms_out_if.sv
design/dctms_batch.sv
design/dual_channel_trimmed_mean_sampler.sv
dv/tb.sv
